@@ rtl/shrx_pkg.sv @@
// Shared types, constants and the byte mixing function of the string hash block.
package shrx_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DivCntW = $clog2(HashW);

  typedef logic [HashW-1:0] hash_t;
  typedef logic [ByteW-1:0] byte_t;

  localparam hash_t SlotCountReset = 32'd1024;

  localparam hash_t MixTable [16] = '{
    32'h49848f1b, 32'he6255dba, 32'h36da5bdc, 32'h47bf94e9,
    32'h8cbcce22, 32'h559fc06a, 32'hd268f536, 32'he10af79a,
    32'hc1af4d69, 32'h1d2917b5, 32'hec4c304d, 32'h9ee5016c,
    32'h69232f74, 32'hfead7bb3, 32'he9089ab6, 32'hf012f6ae
  };

  typedef struct packed {
    logic acc_en;
    logic start;
    logic step;
    logic out_load;
  } shrx_cmd_t;

  function automatic hash_t mix_byte(input hash_t acc, input byte_t b);
    hash_t      t1;
    hash_t      r1;
    hash_t      t2;
    logic [3:0] i1;
    logic [3:0] i2;
    i1 = b[3:0] + acc[3:0];
    t1 = acc ^ MixTable[i1];
    r1 = {t1[HashW-2:0], t1[HashW-1]};
    i2 = b[7:4] + r1[3:0];
    t2 = r1 ^ MixTable[i2];
    return {t2[HashW-3:0], t2[HashW-1:HashW-2]};
  endfunction

endpackage

@@ rtl/shrx_if.sv @@
// Handshake channel interfaces for key bytes, hash results and the slot count register.
interface shrx_in_if;
  logic                 valid;
  logic                 ready;
  shrx_pkg::byte_t      byte_value;
  logic                 has_byte;
  logic                 key_end;

  modport source (output valid, output byte_value, output has_byte, output key_end,
                  input ready);
  modport sink   (input valid, input byte_value, input has_byte, input key_end,
                  output ready);
endinterface

interface shrx_out_if;
  logic                 valid;
  logic                 ready;
  shrx_pkg::hash_t      slot_index;
  shrx_pkg::hash_t      full_hash;

  modport source (output valid, output slot_index, output full_hash, input ready);
  modport sink   (input valid, input slot_index, input full_hash, output ready);
endinterface

interface shrx_cfg_if;
  logic                 valid;
  logic                 ready;
  shrx_pkg::hash_t      slot_count;

  modport source (output valid, output slot_count, input ready);
  modport sink   (input valid, input slot_count, output ready);
endinterface

@@ rtl/shrx_ctrl.sv @@
// Controller state machine that sequences byte intake, the remainder steps and result hand-off.
module shrx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                key_end_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output shrx_pkg::shrx_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e                         state_q, state_d;
  logic [shrx_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (key_end_i) begin
            cmd_o.start = 1'b1;
            cnt_d       = '1;
            state_d     = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/shrx_dp.sv @@
// Datapath with the hash accumulator, the slot count register and a bit-serial remainder unit.
module shrx_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shrx_pkg::shrx_cmd_t cmd_i,
  input  shrx_pkg::byte_t     byte_value_i,
  input  logic                has_byte_i,
  input  logic                cfg_valid_i,
  input  shrx_pkg::hash_t     cfg_data_i,
  output shrx_pkg::hash_t     slot_index_o,
  output shrx_pkg::hash_t     full_hash_o
);

  shrx_pkg::hash_t           acc_q, acc_d;
  shrx_pkg::hash_t           slot_count_q;
  shrx_pkg::hash_t           hash_q;
  shrx_pkg::hash_t           quo_q;
  shrx_pkg::hash_t           rem_q;
  shrx_pkg::hash_t           slot_index_q;
  shrx_pkg::hash_t           full_hash_q;
  shrx_pkg::hash_t           mixed;
  logic [shrx_pkg::HashW:0]  rem_sh;
  logic [shrx_pkg::HashW:0]  divisor;
  logic [shrx_pkg::HashW:0]  diff;
  shrx_pkg::hash_t           rem_d;

  assign mixed   = has_byte_i ? shrx_pkg::mix_byte(acc_q, byte_value_i) : acc_q;
  assign rem_sh  = {rem_q, quo_q[shrx_pkg::HashW-1]};
  assign divisor = {1'b0, slot_count_q};
  assign diff    = rem_sh - divisor;
  assign rem_d   = (rem_sh >= divisor) ? diff[shrx_pkg::HashW-1:0]
                                       : rem_sh[shrx_pkg::HashW-1:0];

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_en) begin
      acc_d = cmd_i.start ? '0 : mixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      slot_count_q <= shrx_pkg::SlotCountReset;
    end else begin
      acc_q <= acc_d;
      if (cfg_valid_i) begin
        slot_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hash_q <= mixed;
      quo_q  <= mixed;
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[shrx_pkg::HashW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      full_hash_q  <= hash_q;
      slot_index_q <= (slot_count_q == '0) ? '0 : rem_q;
    end
  end

  assign slot_index_o = slot_index_q;
  assign full_hash_o  = full_hash_q;

endmodule

@@ rtl/string_hash_rotate_xor_mod.sv @@
// Top level of the streaming string hash with table-driven rotate-xor mixing and slot reduction.
//
// Key bytes enter one word per cycle on key_i while it is ready and are folded into a 32-bit
// accumulator. The word that carries key_end closes the key: the final hash goes to a
// bit-serial remainder unit that produces one quotient bit per cycle, and the remainder then
// loads into the result register; key_i is not ready from the closing word until that load.
// The result register lets the next key start while a finished result still waits on
// hash_o; a further closing word then holds key_i off until hash_o takes that result.
// A slot count of zero yields a slot index of zero. The slot count register resets to
// 1024 and is written on cfg_i, which is always ready.
module string_hash_rotate_xor_mod (
  input  logic      clk_i,
  input  logic      rst_ni,
  shrx_cfg_if.sink  cfg_i,
  shrx_in_if.sink   key_i,
  shrx_out_if.source hash_o
);

  shrx_pkg::shrx_cmd_t cmd;
  logic                in_ready;
  logic                out_valid;

  assign cfg_i.ready  = 1'b1;
  assign key_i.ready  = in_ready;
  assign hash_o.valid = out_valid;

  shrx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_i.valid),
    .key_end_i   (key_i.key_end),
    .out_ready_i (hash_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  shrx_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .byte_value_i (key_i.byte_value),
    .has_byte_i   (key_i.has_byte),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_data_i   (cfg_i.slot_count),
    .slot_index_o (hash_o.slot_index),
    .full_hash_o  (hash_o.full_hash)
  );

endmodule

@@ rtl/shrx_checker.sv @@
// Port-level assertions for the string hash block and the bind that attaches them.
module shrx_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_valid_i,
  input logic            cfg_ready_i,
  input shrx_pkg::hash_t cfg_slot_count_i,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_key_end_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input shrx_pkg::hash_t out_slot_index_i,
  input shrx_pkg::hash_t out_full_hash_i
);

  shrx_pkg::hash_t slot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= shrx_pkg::SlotCountReset;
    end else if (cfg_valid_i && cfg_ready_i) begin
      slot_count_q <= cfg_slot_count_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_slot_index_i) && $stable(out_full_hash_i))
    else $error("Stalled result word changed or was dropped.");

  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_key_end_i |=> !in_ready_i)
    else $error("Key bytes accepted while the remainder unit is busy.");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((slot_count_q == '0) && (out_slot_index_i == '0)) ||
      ((slot_count_q != '0) && (out_slot_index_i < slot_count_q)))
    else $error("Slot index is not below the slot count.");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("Result word appeared without a finished remainder pass.");

endmodule

bind string_hash_rotate_xor_mod shrx_checker u_shrx_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_valid_i      (cfg_i.valid),
  .cfg_ready_i      (cfg_i.ready),
  .cfg_slot_count_i (cfg_i.slot_count),
  .in_valid_i       (key_i.valid),
  .in_ready_i       (key_i.ready),
  .in_key_end_i     (key_i.key_end),
  .out_valid_i      (hash_o.valid),
  .out_ready_i      (hash_o.ready),
  .out_slot_index_i (hash_o.slot_index),
  .out_full_hash_i  (hash_o.full_hash)
);

@@ tb/shrx_checker.sv @@
// Checker that predicts the slot index and full hash of each key and compares them with hash_o.
`timescale 1ns / 100ps

module shrx_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  shrx_cfg_if         cfg_i,
  shrx_in_if          key_i,
  shrx_out_if         hash_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam shrx_pkg::hash_t SlotDivisorReset = 32'd1024;
  localparam shrx_pkg::hash_t NibbleMask       = 32'h0000_000f;

  localparam shrx_pkg::hash_t MixWords [16] = '{
    32'h49848f1b, 32'he6255dba, 32'h36da5bdc, 32'h47bf94e9,
    32'h8cbcce22, 32'h559fc06a, 32'hd268f536, 32'he10af79a,
    32'hc1af4d69, 32'h1d2917b5, 32'hec4c304d, 32'h9ee5016c,
    32'h69232f74, 32'hfead7bb3, 32'he9089ab6, 32'hf012f6ae
  };

  typedef struct packed {
    shrx_pkg::hash_t slot_index;
    shrx_pkg::hash_t full_hash;
  } hash_result_t;

  shrx_pkg::hash_t slot_divisor;
  shrx_pkg::hash_t running_hash;
  hash_result_t    pending_results [$];
  int unsigned     fails;

  function automatic shrx_pkg::hash_t rotate_left(input shrx_pkg::hash_t v,
                                                  input int unsigned n);
    return (v << n) | (v >> (shrx_pkg::HashW - n));
  endfunction

  function automatic shrx_pkg::hash_t fold_key_byte(input shrx_pkg::hash_t acc,
                                                    input shrx_pkg::byte_t b);
    shrx_pkg::hash_t a;
    logic [3:0]      idx;
    a = acc;
    idx = 4'((shrx_pkg::hash_t'(b) + a) & NibbleMask);
    a = a ^ MixWords[idx];
    a = rotate_left(a, 1);
    idx = 4'((shrx_pkg::hash_t'(b >> 4) + a) & NibbleMask);
    a = a ^ MixWords[idx];
    a = rotate_left(a, 2);
    return a;
  endfunction

  function automatic shrx_pkg::hash_t reduce_to_slot(input shrx_pkg::hash_t h,
                                                     input shrx_pkg::hash_t divisor);
    return (divisor != '0) ? h % divisor : '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hash_result_t want;
    if (!rst_ni) begin
      slot_divisor = SlotDivisorReset;
      running_hash = '0;
      pending_results.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (hash_i.valid && hash_i.ready) begin
        if (pending_results.size() == 0) begin
          $error("Unexpected result: slot_index %0h, full_hash %0h",
                 hash_i.slot_index, hash_i.full_hash);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (hash_i.slot_index !== want.slot_index) begin
            $error("slot_index mismatch: expected %0h, actual %0h",
                   want.slot_index, hash_i.slot_index);
            fails++;
          end
          if (hash_i.full_hash !== want.full_hash) begin
            $error("full_hash mismatch: expected %0h, actual %0h",
                   want.full_hash, hash_i.full_hash);
            fails++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        slot_divisor = cfg_i.slot_count;
      end
      if (key_i.valid && key_i.ready) begin
        if (key_i.has_byte) begin
          running_hash = fold_key_byte(running_hash, key_i.byte_value);
        end
        if (key_i.key_end) begin
          want.slot_index = reduce_to_slot(running_hash, slot_divisor);
          want.full_hash  = running_hash;
          pending_results.push_back(want);
          running_hash = '0;
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= pending_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top that drives keys, slot counts and result stalls into the string hash block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned ItemsPerPhase = 140;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned HoldPhase     = 2;
  localparam int unsigned PausePhase    = 4;
  localparam int unsigned SteadyPhase   = 5;
  localparam int unsigned DirectedCount = 17;

  typedef struct packed {
    shrx_pkg::byte_t b;
    logic            has;
    logic            last;
  } key_word_t;

  localparam key_word_t DirectedWords [DirectedCount] = '{
    '{8'h00, 1'b0, 1'b1},
    '{8'h00, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'hff, 1'b1, 1'b1},
    '{8'h41, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b0},
    '{8'h42, 1'b1, 1'b1},
    '{8'h0f, 1'b1, 1'b0},
    '{8'hf0, 1'b1, 1'b0},
    '{8'h55, 1'b1, 1'b0},
    '{8'haa, 1'b1, 1'b1},
    '{8'h80, 1'b1, 1'b0},
    '{8'h5a, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b1},
    '{8'hc3, 1'b0, 1'b1}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;

  shrx_cfg_if cfg_ch ();
  shrx_in_if  key_ch ();
  shrx_out_if hash_ch ();

  string_hash_rotate_xor_mod dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .key_i  (key_ch),
    .hash_o (hash_ch)
  );

  shrx_scoreboard hash_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_ch),
    .key_i      (key_ch),
    .hash_i     (hash_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit take_gap();
    return idle_en && ($urandom_range(99) < 8);
  endfunction

  task automatic send_word(input shrx_pkg::byte_t b, input logic has, input logic last);
    while (take_gap()) begin
      key_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_ch.valid      <= 1'b1;
    key_ch.byte_value <= b;
    key_ch.has_byte   <= has;
    key_ch.key_end    <= last;
    do @(posedge clk_i); while (!key_ch.ready);
  endtask

  task automatic send_random_key(inout int unsigned sent);
    int unsigned len;
    bit          marker_end;
    len = ($urandom_range(99) < 6) ? 0 :
          ($urandom_range(99) < 10) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    marker_end = (len == 0) || ($urandom_range(99) < 10);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        send_word(shrx_pkg::byte_t'($urandom), 1'b0, 1'b0);
      end
      send_word(shrx_pkg::byte_t'($urandom), 1'b1, (i == len - 1) && !marker_end);
    end
    if (marker_end) begin
      send_word(shrx_pkg::byte_t'($urandom), 1'b0, 1'b1);
    end
    sent += len + (marker_end ? 1 : 0);
  endtask

  task automatic drain();
    key_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input shrx_pkg::hash_t value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.slot_count <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    forever begin
      if (hold_req) begin
        hash_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        hash_ch.ready <= !take_gap();
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((key_ch.valid && key_ch.ready) || (hash_ch.valid && hash_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    shrx_pkg::hash_t slots [PhaseCount];
    int unsigned     sent;
    bit              paused;
    rst_ni            <= 1'b0;
    key_ch.valid      <= 1'b0;
    key_ch.byte_value <= '0;
    key_ch.has_byte   <= 1'b0;
    key_ch.key_end    <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.slot_count <= '0;
    slots = '{32'd1, 32'hffff_ffff, 32'd0, 32'd7, 32'd1000, 32'h8000_0000,
              shrx_pkg::hash_t'($urandom), shrx_pkg::hash_t'($urandom_range(2, 65535))};
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedWords[i]) begin
      send_word(DirectedWords[i].b, DirectedWords[i].has, DirectedWords[i].last);
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      write_slot_count(slots[p]);
      idle_en = (p != SteadyPhase);
      if (p == HoldPhase) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if (p == PausePhase && !paused && sent >= ItemsPerPhase / 2) begin
          drain();
          paused = 1'b1;
        end
        send_random_key(sent);
      end
      drain();
      repeat (SettleCycles) @(posedge clk_i);
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/shrx_pkg.sv
rtl/shrx_if.sv
rtl/shrx_ctrl.sv
rtl/shrx_dp.sv
rtl/string_hash_rotate_xor_mod.sv
rtl/shrx_checker.sv
tb/shrx_checker.sv
tb/tb.sv
